FILE: rtl/erm_pkg.sv
package erm_pkg;

  // Field and state widths.
  localparam int STAMP_W   = 32;
  localparam int SF_W      = 10;
  localparam int SC_W      = 6;
  localparam int SAMPLE_W  = 20;
  localparam int SUM_W     = 27;
  localparam int TAKEN_W   = 7;

  // Pulse widths of 2^44 or more saturate unless the speed factor is zero, so only the low bits are multiplied.
  localparam int WLO_W     = 44;
  localparam int PROD_W    = WLO_W + SF_W;
  localparam int DVSR_W    = 23;
  localparam int DIV_CNT_W = $clog2(SAMPLE_W + 1);

  localparam logic [DVSR_W-1:0]   SCALE_DIV  = 23'd8000000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  // Smallest product whose scaled value no longer fits in a sample.
  localparam logic [PROD_W-1:0]   SAT_LIMIT  =
    PROD_W'({SCALE_DIV, {SAMPLE_W{1'b0}}});

  // The scale divisor is an odd factor times 2^9. The odd part is removed with a truncated
  // reciprocal of 2^34 / 15625, which is never more than one below the true quotient.
  localparam int                 SCALE_SH  = 9;
  localparam int                 ODD_W     = 14;
  localparam int                 QX_W      = SAMPLE_W + ODD_W;
  localparam int                 RECIP_W   = 21;
  localparam int                 RMUL_W    = QX_W + RECIP_W;
  localparam logic [ODD_W-1:0]   SCALE_ODD = 14'd15625;
  localparam logic [RECIP_W-1:0] RECIP_M   = 21'd1099511;

  // Configuration register reset values and indexes.
  localparam logic [SF_W-1:0]     SPEED_RST  = 10'd340;
  localparam logic [SC_W-1:0]     COUNT_RST  = 6'd7;
  localparam int                  CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

  // Queue between the front and back ends.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // Request to and response from the divider.
  typedef struct packed {
    logic                start;
    logic [PROD_W-1:0]   dividend;
    logic [DVSR_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/erm_div.sv
module erm_div import erm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]    rem_r;
  logic [PROD_W-1:0]    dsh_r;
  logic [SAMPLE_W-1:0]  quo_r;
  logic                 ge;

  // One quotient bit per cycle; the caller guarantees the quotient fits in a sample.
  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(SAMPLE_W);
        rem_r  <= req.dividend;
        dsh_r  <= PROD_W'({req.divisor, {(SAMPLE_W-1){1'b0}}});
        quo_r  <= '0;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        dsh_r <= dsh_r >> 1;
        quo_r <= {quo_r[SAMPLE_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // A new division is only started once the previous one has finished.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  // The busy phase always leaves a step count to run.
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with no steps left");

endmodule

FILE: rtl/erm_queue.sv
module erm_queue import erm_pkg::*; #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              valid
);

  logic [DATA_W-1:0] mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = cnt_r == QCNT_W'(QDEPTH);
  assign valid    = cnt_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");

  // The back end never reads from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("queue underflow");

endmodule

FILE: rtl/erm_front.sv
module erm_front import erm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_echo_level,
  input  logic [STAMP_W-1:0]   in_time_stamp,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [TIME_BITS-1:0] q_width
);

  // Only the low bits of the stamp that the time base covers are kept.
  localparam int SB = (TIME_BITS < STAMP_W) ? TIME_BITS : STAMP_W;

  logic [SB-1:0]        rise_r;
  logic                 accept;
  logic [TIME_BITS-1:0] stamp_ext;
  logic [TIME_BITS-1:0] rise_ext;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // Pulse width wraps modulo the time base.
  assign stamp_ext = TIME_BITS'(in_time_stamp[SB-1:0]);
  assign rise_ext  = TIME_BITS'(rise_r);
  assign q_width   = stamp_ext - rise_ext;

  // A falling edge hands its pulse width to the back end.
  assign q_push    = accept && !in_echo_level;

  // A rising edge records its time stamp.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r <= '0;
    end else if (accept && in_echo_level) begin
      rise_r <= in_time_stamp[SB-1:0];
    end
  end

endmodule

FILE: rtl/erm_back.sv
module erm_back import erm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SF_W-1:0]      speed_factor,
  input  logic [SC_W-1:0]      sample_count,
  input  logic                 q_valid,
  input  logic [TIME_BITS-1:0] q_width,
  output logic                 q_pop,
  output div_req_t             div_req,
  input  div_rsp_t             div_rsp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  out_mean_distance
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SCHK, S_RMUL, S_QEST, S_QFIX, S_ACC, S_TRIM, S_MDIV, S_OUT
  } state_t;

  state_t               state_r;
  logic [TIME_BITS-1:0] width_r;
  logic [PROD_W-1:0]    prod_r;
  logic                 big_r;
  logic                 zero_r;
  logic [RMUL_W-1:0]    rmul_r;
  logic [SAMPLE_W-1:0]  qest_r;
  logic [QX_W-1:0]      qprod_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SAMPLE_W-1:0]  max_r;
  logic [SAMPLE_W-1:0]  min_r;
  logic [TAKEN_W-1:0]   taken_r;
  logic [SAMPLE_W-1:0]  mean_r;
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_mean_r;

  logic [WLO_W-1:0]     wlo;
  logic                 big_c;
  logic [PROD_W-1:0]    prod_c;
  logic                 sample_sat;
  logic [QX_W-1:0]      scaled_x;
  logic [SAMPLE_W-1:0]  qest_c;
  logic [QX_W-1:0]      qrem_c;
  logic                 qfix_c;
  logic [SUM_W-1:0]     sum_acc;
  logic [TAKEN_W-1:0]   taken_acc;
  logic                 batch_end;
  logic [SAMPLE_W:0]    pair_c;
  logic [SUM_W-1:0]     trim_c;
  logic [SUM_W-1:0]     mean_limit;
  logic                 mean_sat;
  logic                 out_load;

  // Scaling product; very wide pulses are flagged rather than multiplied.
  assign wlo    = WLO_W'(width_r);
  assign big_c  = (width_r >> WLO_W) != '0;
  assign prod_c = {{(PROD_W-WLO_W){1'b0}}, wlo} * {{(PROD_W-SF_W){1'b0}}, speed_factor};
  assign sample_sat = big_r || (prod_r >= SAT_LIMIT);

  // Scaling by the constant divisor: drop its power-of-two factor, estimate the quotient
  // by the odd part with the reciprocal, and add one where the remainder is still too big.
  assign scaled_x = QX_W'(prod_r >> SCALE_SH);
  assign qest_c   = rmul_r[QX_W +: SAMPLE_W];
  assign qrem_c   = scaled_x - qprod_r;
  assign qfix_c   = qrem_c >= QX_W'(SCALE_ODD);

  // Running sum and sample count after the current sample.
  assign sum_acc   = sum_r + SUM_W'(sample_r);
  assign taken_acc = taken_r + 1'b1;
  assign batch_end = {1'b0, taken_acc} >= ({2'b00, sample_count} + 8'd2);

  // Sum less the extremes, clamped at zero.
  assign pair_c     = {1'b0, max_r} + {1'b0, min_r};
  assign trim_c     = (sum_r < SUM_W'(pair_c)) ? '0 : sum_r - SUM_W'(pair_c);
  assign mean_limit = SUM_W'({sample_count, {SAMPLE_W{1'b0}}});
  assign mean_sat   = trim_c >= mean_limit;

  // The divider forms the batch mean.
  always_comb begin
    div_req.start    = (state_r == S_TRIM) && (sample_count != '0) && !mean_sat;
    div_req.dividend = PROD_W'(trim_c);
    div_req.divisor  = DVSR_W'(sample_count);
  end

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Sequencer, batch state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      max_r       <= '0;
      min_r       <= SAMPLE_MAX;
      taken_r     <= '0;
    end else begin
      // The output register fills from the sequencer and empties when its request is taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            width_r <= q_width;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= prod_c;
          big_r   <= big_c;
          zero_r  <= speed_factor == '0;
          state_r <= S_SCHK;
        end
        S_SCHK: begin
          if (zero_r) begin
            sample_r <= '0;
            state_r  <= S_ACC;
          end else if (sample_sat) begin
            sample_r <= SAMPLE_MAX;
            state_r  <= S_ACC;
          end else begin
            state_r  <= S_RMUL;
          end
        end
        S_RMUL: begin
          rmul_r  <= {{RECIP_W{1'b0}}, scaled_x} * {{QX_W{1'b0}}, RECIP_M};
          state_r <= S_QEST;
        end
        S_QEST: begin
          qest_r  <= qest_c;
          qprod_r <= {{ODD_W{1'b0}}, qest_c} * {{SAMPLE_W{1'b0}}, SCALE_ODD};
          state_r <= S_QFIX;
        end
        S_QFIX: begin
          sample_r <= qest_r + SAMPLE_W'(qfix_c);
          state_r  <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_acc;
          taken_r <= taken_acc;
          if (sample_r > max_r) begin
            max_r <= sample_r;
          end
          if (sample_r < min_r) begin
            min_r <= sample_r;
          end
          state_r <= batch_end ? S_TRIM : S_IDLE;
        end
        S_TRIM: begin
          sum_r   <= '0;
          max_r   <= '0;
          min_r   <= SAMPLE_MAX;
          taken_r <= '0;
          if (sample_count == '0) begin
            mean_r  <= '0;
            state_r <= S_OUT;
          end else if (mean_sat) begin
            mean_r  <= SAMPLE_MAX;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            mean_r  <= div_rsp.quotient;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_mean_r <= mean_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_distance = out_mean_r;

  // Finishing a batch always starts the next one empty.
  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRIM) |=> (taken_r == '0))
    else $error("batch not cleared after result");

  // Once a batch holds a sample, the maximum cannot lie below the minimum.
  a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    (taken_r != '0) |-> (max_r >= min_r))
    else $error("largest sample below smallest sample");

endmodule

FILE: rtl/echo_range_trimmed_mean.sv
// A rising edge is absorbed in the cycle it is accepted. A falling edge keeps the back end
// busy through multiply, saturation check, reciprocal scaling (unless zero or saturated) and
// accumulate; the edge that closes a batch then trims the sum and, unless the mean is zero
// or saturated, divides it; the back end takes no new falling edge meanwhile, a two-entry queue lets the
// front end keep accepting, and a result held at the output stalls the back end.
// Reset: rst_n is synchronous, active low; it empties the batch and queue and restores config.
module echo_range_trimmed_mean import erm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_echo_level,
  input  logic [STAMP_W-1:0]   in_time_stamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  out_mean_distance,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SF_W-1:0]      cfg_data
);

  logic [SF_W-1:0]      speed_r;
  logic [SC_W-1:0]      count_r;
  logic                 q_full;
  logic                 q_push;
  logic [TIME_BITS-1:0] q_width_in;
  logic                 q_valid;
  logic                 q_pop;
  logic [TIME_BITS-1:0] q_width_out;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RST;
      count_r <= COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPEED: speed_r <= cfg_data;
        CFG_COUNT: count_r <= cfg_data[SC_W-1:0];
        default:   ;
      endcase
    end
  end

  erm_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_echo_level (in_echo_level),
    .in_time_stamp (in_time_stamp),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_width       (q_width_in)
  );

  erm_queue #(.DATA_W(TIME_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_width_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_width_out),
    .valid     (q_valid)
  );

  erm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  erm_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .speed_factor      (speed_r),
    .sample_count      (count_r),
    .q_valid           (q_valid),
    .q_width           (q_width_out),
    .q_pop             (q_pop),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_distance (out_mean_distance)
  );

endmodule

FILE: dv/erm_mean_checker.sv
`timescale 1ns / 1ps

// Watches the edge, result and register channels, keeps its own copy of the ranging
// arithmetic and compares every mean accepted from the block with the expected one.
module erm_mean_checker import erm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_echo_level,
  input  logic [STAMP_W-1:0]   in_time_stamp,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [SAMPLE_W-1:0]  out_mean_distance,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SF_W-1:0]      cfg_data,
  output int                   mismatch_count,
  output int                   pending_means
);

  // Predicted configuration and batch state.
  logic [SF_W-1:0]     speed;
  logic [SC_W-1:0]     batch_count;
  logic [STAMP_W-1:0]  last_rise;
  logic [TAKEN_W-1:0]  taken;
  logic [SUM_W-1:0]    batch_sum;
  logic [SAMPLE_W-1:0] batch_max;
  logic [SAMPLE_W-1:0] batch_min;
  logic [SAMPLE_W-1:0] mean_q[$];
  int                  errors = 0;

  // Distance sample from one pulse width: scaled, divided and clipped to the sample range.
  function automatic logic [SAMPLE_W-1:0] scaled_distance(input logic [STAMP_W-1:0] width,
                                                          input logic [SF_W-1:0]    spd);
    logic [63:0] q;
    q = (64'(width) * 64'(spd)) / 64'(SCALE_DIV);
    return (q > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : q[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] expected;
    logic [SUM_W:0]      extremes;
    logic [SUM_W:0]      trimmed;
    logic [SUM_W:0]      quot;

    if (!rst_n) begin
      speed       = SPEED_RST;
      batch_count = COUNT_RST;
      last_rise   = '0;
      taken       = '0;
      batch_sum   = '0;
      batch_max   = '0;
      batch_min   = SAMPLE_MAX;
      mean_q.delete();
    end else begin
      // Compare an accepted mean with the oldest one still awaited.
      if (out_valid && out_ready) begin
        if (mean_q.size() == 0) begin
          $error("mean_distance: no request awaiting a result, got %0d", out_mean_distance);
          errors++;
        end else begin
          expected = mean_q.pop_front();
          if (expected !== out_mean_distance) begin
            $error("mean_distance: expected %0d, got %0d", expected, out_mean_distance);
            errors++;
          end
        end
      end

      // Register writes take effect at once; unknown indexes are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEED: speed = cfg_data;
          CFG_COUNT: batch_count = cfg_data[SC_W-1:0];
          default: ;
        endcase
      end

      // A rising edge only records its time; a falling edge adds one sample to the batch.
      if (in_valid && in_ready) begin
        if (in_echo_level) begin
          last_rise = in_time_stamp;
        end else begin
          sample    = scaled_distance(in_time_stamp - last_rise, speed);
          batch_sum = batch_sum + SUM_W'(sample);
          if (sample > batch_max) batch_max = sample;
          if (sample < batch_min) batch_min = sample;
          taken = taken + 1'b1;

          // Close the batch: drop the extremes and average the rest.
          if (taken >= TAKEN_W'(batch_count) + TAKEN_W'(2)) begin
            extremes = (SUM_W+1)'(batch_max) + (SUM_W+1)'(batch_min);
            if ({1'b0, batch_sum} < extremes) begin
              trimmed = '0;
            end else begin
              trimmed = {1'b0, batch_sum} - extremes;
            end
            quot = (batch_count == 0) ? '0 : trimmed / (SUM_W+1)'(batch_count);
            expected = (quot > (SUM_W+1)'(SAMPLE_MAX)) ? SAMPLE_MAX : quot[SAMPLE_W-1:0];
            mean_q.push_back(expected);
            taken     = '0;
            batch_sum = '0;
            batch_max = '0;
            batch_min = SAMPLE_MAX;
          end
        end
      end
    end

    mismatch_count <= errors;
    pending_means  <= mean_q.size();
  end

endmodule

FILE: dv/tb_echo_range_trimmed_mean.sv
`timescale 1ns / 1ps

module tb_echo_range_trimmed_mean;
  import erm_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_EDGES  = 1100;
  localparam int LONG_HOLD     = 1000;
  localparam int HOLD_PHASE    = 2;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic                 in_echo_level = 1'b0;
  logic [STAMP_W-1:0]   in_time_stamp = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [SAMPLE_W-1:0]  out_mean_distance;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [SF_W-1:0]      cfg_data      = '0;

  int   mismatch_count;
  int   pending_means;
  int   quiet_cycles  = 0;
  int   send_idle_pct = 0;
  logic hold_request  = 1'b0;

  always #5 clk = ~clk;

  echo_range_trimmed_mean i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_echo_level     (in_echo_level),
    .in_time_stamp     (in_time_stamp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_distance (out_mean_distance),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  erm_mean_checker u_mean_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_echo_level     (in_echo_level),
    .in_time_stamp     (in_time_stamp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_distance (out_mean_distance),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .pending_means     (pending_means)
  );

  // Watchdog: the run is stuck if no channel moves a request for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: short and long stalls, steady stretches, and one long hold-off.
  initial begin
    int stall_left;
    int steady_left;
    int r;
    bit hold_done;
    stall_left  = 0;
    steady_left = 0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (hold_request && !hold_done) begin
          stall_left = LONG_HOLD;
          hold_done  = 1'b1;
        end else if (steady_left > 0) begin
          steady_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5) begin
            steady_left = $urandom_range(50, 200);
          end else if (r >= 60 && r < 90) begin
            stall_left = $urandom_range(1, 3);
          end else if (r >= 90 && r < 98) begin
            stall_left = $urandom_range(4, 12);
          end else if (r >= 98) begin
            stall_left = $urandom_range(20, 80);
          end
        end
      end
    end
  end

  // Offer one edge request and hold it until taken, then maybe leave a gap.
  task automatic send_edge(input logic level, input logic [STAMP_W-1:0] stamp);
    int gap;
    in_valid      <= 1'b1;
    in_echo_level <= level;
    in_time_stamp <= stamp;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Valid is left high so that writes can follow back to back; the caller lowers it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop sending, wait for every awaited mean, then let any trailing sample drain.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_means != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                 sent;
    int                 phase_index;
    int                 phase_len;
    int                 phase_sent;
    int                 k;
    logic [SF_W-1:0]    new_speed;
    logic [SC_W-1:0]    new_count;
    logic [STAMP_W-1:0] rise_stamp;
    logic [STAMP_W-1:0] width;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed edges at the reset settings: a fall with no rise, a wrapped pulse,
    // repeated rises, the widest pulse, a zero-width pulse and a second fall.
    send_idle_pct = 30;
    send_edge(1'b0, 32'h0000_4000);
    send_edge(1'b1, 32'hFFFF_F000);
    send_edge(1'b0, 32'h0000_1000);
    send_edge(1'b1, 32'h0000_0000);
    send_edge(1'b1, 32'h0000_0010);
    send_edge(1'b0, 32'hFFFF_FFFF);
    send_edge(1'b1, 32'h1234_5678);
    send_edge(1'b0, 32'h1234_5678);
    send_edge(1'b0, 32'hFFFF_FFFF);

    // Lower the batch length below the samples already taken, with stray upper data bits.
    wait_for_idle();
    write_register(CFG_COUNT, 10'h3C1);
    write_register(CFG_SPEED, 10'h3FF);
    cfg_valid <= 1'b0;
    send_edge(1'b1, 32'h0000_0000);
    send_edge(1'b0, 32'hFFFF_FFFF);

    // Zero speed and zero batch count: two zero samples give a zero mean.
    wait_for_idle();
    write_register(CFG_SPEED, '0);
    write_register(CFG_COUNT, '0);
    cfg_valid <= 1'b0;
    send_edge(1'b1, 32'h8000_0000);
    send_edge(1'b0, 32'h7FFF_FFFF);
    send_edge(1'b0, 32'hAAAA_AAAA);

    // Writes to undecoded indexes must change nothing.
    wait_for_idle();
    write_register(CFG_SPARE_LO, 10'h155);
    write_register(CFG_SPARE_HI, 10'h2AA);
    write_register(CFG_SPEED, 10'd1);
    write_register(CFG_COUNT, 10'd63);
    cfg_valid <= 1'b0;

    // Random phases, each with its own settings and pacing.
    sent        = 0;
    phase_index = 0;
    while (sent < RANDOM_EDGES) begin
      wait_for_idle();

      case ($urandom_range(0, 5))
        0:       new_speed = '0;
        1:       new_speed = 10'd1;
        2:       new_speed = 10'h3FF;
        3:       new_speed = SPEED_RST;
        default: new_speed = SF_W'($urandom_range(1, 1023));
      endcase
      case ($urandom_range(0, 7))
        0:       new_count = '0;
        1:       new_count = 6'd63;
        2:       new_count = 6'd1;
        3, 4:    new_count = SC_W'($urandom_range(2, 8));
        5:       new_count = SC_W'($urandom_range(9, 62));
        default: new_count = SC_W'($urandom_range(1, 5));
      endcase
      send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 10 * $urandom_range(1, 6);

      // One phase is run with short batches and no idling while the result side holds off.
      if (phase_index == HOLD_PHASE) begin
        new_count     = 6'd1;
        send_idle_pct = 0;
        hold_request <= 1'b1;
      end

      case ($urandom_range(0, 3))
        0: write_register(CFG_SPEED, new_speed);
        1: write_register(CFG_COUNT, {4'($urandom()), new_count});
        2: begin
          write_register(CFG_SPEED, new_speed);
          write_register(CFG_COUNT, {4'($urandom()), new_count});
        end
        default: begin
          write_register(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                         SF_W'($urandom()));
          write_register(CFG_COUNT, {4'($urandom()), new_count});
          write_register(CFG_SPEED, new_speed);
        end
      endcase
      cfg_valid <= 1'b0;

      // Long batches need long phases for their means to appear.
      if (new_count > 8) begin
        phase_len = 2 * (int'(new_count) + 2) * $urandom_range(1, 2) + $urandom_range(0, 20);
      end else begin
        phase_len = $urandom_range(20, 90);
      end

      // Mostly rise-fall pairs of varied width; the rest lone falls and repeated rises.
      phase_sent = 0;
      while (phase_sent < phase_len) begin
        k = $urandom_range(0, 99);
        if (k < 85) begin
          rise_stamp = $urandom();
          case ($urandom_range(0, 3))
            0:       width = STAMP_W'($urandom_range(0, 255));
            1:       width = STAMP_W'($urandom_range(0, 65535));
            2:       width = STAMP_W'($urandom_range(0, 1 << 24));
            default: width = $urandom();
          endcase
          send_edge(1'b1, rise_stamp);
          send_edge(1'b0, rise_stamp + width);
          phase_sent += 2;
        end else if (k < 92) begin
          send_edge(1'b0, $urandom());
          phase_sent++;
        end else begin
          send_edge(1'b1, $urandom());
          phase_sent++;
        end
      end
      sent += phase_sent;
      phase_index++;
    end

    // Drain and give the verdict.
    wait_for_idle();
    if (mismatch_count == 0 && pending_means == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/erm_pkg.sv
rtl/erm_div.sv
rtl/erm_queue.sv
rtl/erm_front.sv
rtl/erm_back.sv
rtl/echo_range_trimmed_mean.sv
dv/erm_mean_checker.sv
dv/tb_echo_range_trimmed_mean.sv
